/* design/assert_macros.svh */
// Assertion macros shared by the frame check RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/cfc_pkg.sv */
// Shared types, constants and the CRC byte update for the frame checker.
`default_nettype none
package cfc_pkg;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [1:0]  CntMax  = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic        frame_done;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
    logic        crc_match;
    logic        length_ok;
  } result_t;

  // Reflected CRC-16 update of one byte, LSB first.
  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* design/crc16_frame_check_top.sv */
// Top level of the CRC-16/Modbus frame checker.
// Takes one frame byte per clock while the result is not stalled and returns
// one result per byte through an input register, a combinational unrolled
// 8-bit CRC update with the two-byte trailer delay, and a result register. A byte
// can be taken on every clock; the result register is the only stage that
// holds back input, and only while its result is stalled. Every byte yields
// a transaction on the output; only the one for a frame's final byte has
// frame_done set and carries the computed CRC, the received trailer (high
// byte first) and the match and length flags. Frames under three bytes
// report a zero CRC with both flags clear. The CRC state restarts after
// every final byte.
`default_nettype none
`include "assert_macros.svh"
module crc16_frame_check_top
  import cfc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        frame_last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             frame_done_o,
  output logic [15:0]      computed_crc_o,
  output logic [15:0]      received_crc_o,
  output logic             crc_match_o,
  output logic             length_ok_o
);

  logic     s1_valid;
  in_item_t s1_item;
  logic     out_take;
  logic     advance;
  result_t  core_res;
  result_t  out_res;

  assign advance = s1_valid & out_take;

  cfc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid_i),
    .data_byte_i  (data_byte_i),
    .frame_last_i (frame_last_i),
    .take_i       (out_take),
    .stall_o      (in_stall_o),
    .valid_o      (s1_valid),
    .item_o       (s1_item)
  );

  cfc_check_core u_check_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (s1_item),
    .res_o     (core_res)
  );

  cfc_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .res_i   (core_res),
    .stall_i (out_stall_i),
    .take_o  (out_take),
    .valid_o (out_valid_o),
    .res_o   (out_res)
  );

  assign frame_done_o   = out_res.frame_done;
  assign computed_crc_o = out_res.computed_crc;
  assign received_crc_o = out_res.received_crc;
  assign crc_match_o    = out_res.crc_match;
  assign length_ok_o    = out_res.length_ok;

  // Input backs up only behind a stalled, full result register.
  `ASSERT_CLK_ALWAYS(a_stall_cause,
    in_stall_o |-> (out_valid_o && out_stall_i),
    "input stalled without a stalled result")

endmodule
`default_nettype wire

/* design/cfc_in_stage.sv */
// Input register stage of the frame checker.
`default_nettype none
module cfc_in_stage
  import cfc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       frame_last_i,
  input  wire logic       take_i,
  output logic            stall_o,
  output logic            valid_o,
  output in_item_t        item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;

  // Hold while the registered byte cannot move on.
  assign stall_o = valid_q & ~take_i;
  assign valid_d = stall_o ? valid_q : valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      item_q.data_byte  <= data_byte_i;
      item_q.frame_last <= frame_last_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

/* design/cfc_check_core.sv */
// Frame state, two-byte delay line and CRC update for the frame checker.
`default_nettype none
`include "assert_macros.svh"
module cfc_check_core
  import cfc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     advance_i,
  input  wire in_item_t item_i,
  output result_t       res_o
);

  logic [15:0] crc_q, crc_d;
  logic [7:0]  newer_q, newer_d;
  logic [7:0]  older_q, older_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        enough;
  logic [15:0] crc_next;
  logic [15:0] rx_crc;

  // The byte leaving the delay line is payload once two bytes are held.
  assign enough   = cnt_q[1];
  assign crc_next = enough ? crc16_fold(crc_q, older_q) : crc_q;
  assign rx_crc   = {newer_q, item_i.data_byte};

  always_comb begin
    res_o = '0;
    if (item_i.frame_last) begin
      res_o.frame_done = 1'b1;
      if (enough) begin
        res_o.computed_crc = crc_next;
        res_o.received_crc = rx_crc;
        res_o.crc_match    = (crc_next == rx_crc);
        res_o.length_ok    = 1'b1;
      end
    end
  end

  always_comb begin
    if (item_i.frame_last) begin
      crc_d   = CrcInit;
      newer_d = '0;
      older_d = '0;
      cnt_d   = '0;
    end else begin
      crc_d   = crc_next;
      newer_d = item_i.data_byte;
      older_d = newer_q;
      cnt_d   = (cnt_q == CntMax) ? CntMax : cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CrcInit;
      newer_q <= '0;
      older_q <= '0;
      cnt_q   <= '0;
    end else if (advance_i) begin
      crc_q   <= crc_d;
      newer_q <= newer_d;
      older_q <= older_d;
      cnt_q   <= cnt_d;
    end
  end

  `ASSERT_CLK(a_frame_restart,
    (advance_i && item_i.frame_last) |=> (cnt_q == 2'd0 && crc_q == CrcInit),
    "frame state not restarted after final byte")
  `ASSERT_CLK(a_crc_idle_before_payload,
    (cnt_q != 2'd3) |-> (crc_q == CrcInit),
    "CRC moved before a payload byte left the delay line")
  `ASSERT_CLK(a_match_needs_length,
    res_o.crc_match |-> (res_o.length_ok && res_o.frame_done),
    "match flagged on a short or unfinished frame")

endmodule
`default_nettype wire

/* design/cfc_out_stage.sv */
// Result register stage of the frame checker.
`default_nettype none
module cfc_out_stage
  import cfc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t res_i,
  input  wire logic    stall_i,
  output logic         take_o,
  output logic         valid_o,
  output result_t      res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // Accept a new result when empty or when the held one leaves this cycle.
  assign take_o  = ~valid_q | ~stall_i;
  assign valid_d = take_o ? load_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && take_o) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
`default_nettype wire
